@@ src/fpm_pkg.sv @@
// ----------------------------------------------------------------------------
// fpm_pkg: shared constants and types for the binary32 multiplier
// Field widths, special encodings and the stage structure of the datapath.
// ----------------------------------------------------------------------------
package fpm_pkg;

  localparam int FracBits = 23;
  localparam int ExpBits  = 8;
  localparam logic [31:0] QnanCanon = 32'h7FC0_0000;
  localparam logic [ExpBits-1:0] ExpMax = 8'hFF;

  // Decoded operand pair, held in the input register.
  typedef struct packed {
    logic              sign;
    logic              is_nan;
    logic              is_inf;
    logic              is_zero;
    logic [ExpBits:0]  exp_sum;   // ea + eb, nine bits
    logic [47:0]       mant_prod; // product of the two 24-bit significands
  } fpm_stage_t;

endpackage

@@ src/fpm_round.sv @@
// ----------------------------------------------------------------------------
// fpm_round: normalise, round to nearest even and pack the product
// Handles overflow to infinity, flush to zero and NaN canonicalisation.
// ----------------------------------------------------------------------------
module fpm_round (
  input  fpm_pkg::fpm_stage_t st,
  output logic [31:0]         product
);

  logic        top;
  logic [23:0] q;
  logic        g;
  logic        sticky;
  logic [24:0] qr;
  logic signed [10:0] e;
  logic signed [10:0] e_fin;
  logic [22:0] frac;

  always_comb begin
    top = st.mant_prod[47];
    // Biased exponent: k + ea + eb - 173 with k = 46 or 47.
    e = $signed({2'b00, st.exp_sum}) - 11'sd127 + $signed({10'd0, top});
    if (top) begin
      q      = st.mant_prod[47:24];
      g      = st.mant_prod[23];
      sticky = |st.mant_prod[22:0];
    end else begin
      q      = st.mant_prod[46:23];
      g      = st.mant_prod[22];
      sticky = |st.mant_prod[21:0];
    end
    qr    = {1'b0, q} + {24'd0, g & (sticky | q[0])};
    e_fin = e;
    frac  = qr[22:0];
    if (qr[24]) begin
      e_fin = e + 11'sd1;
      frac  = 23'd0;
    end

    if (st.is_nan) begin
      product = fpm_pkg::QnanCanon;
    end else if (st.is_inf) begin
      product = {st.sign, fpm_pkg::ExpMax, 23'd0};
    end else if (st.is_zero) begin
      product = {st.sign, 31'd0};
    end else if (e == 11'sd0 && q == 24'hFF_FFFF) begin
      // At exponent zero the subnormal rounding keeps one bit fewer; its
      // kept bits are all ones and its round bit is set exactly when the
      // top 24 bits here are all ones, and it then rounds up to the
      // smallest normal.
      product = {st.sign, 8'd1, 23'd0};
    end else if (e <= 11'sd0) begin
      product = {st.sign, 31'd0};
    end else if (e_fin >= 11'sd255) begin
      product = {st.sign, fpm_pkg::ExpMax, 23'd0};
    end else begin
      product = {st.sign, e_fin[7:0], frac};
    end
  end

endmodule

@@ src/fp32_multiplier_daz_ftz.sv @@
// ----------------------------------------------------------------------------
// fp32_multiplier_daz_ftz: binary32 multiplier, DAZ inputs, FTZ output
// Pipeline: a request is captured in the input register and its product in
// the result register. Throughput: one request per cycle while m_tready
// takes the results; the significand multiply sits in front of the input
// register and the rounding between it and the result register.
// Reset: rst clears the valid bits of both stages; data registers keep state.
// ----------------------------------------------------------------------------
module fp32_multiplier_daz_ftz (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // operand_a [31:0], operand_b [63:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // product [31:0]
);

  logic                v1;
  fpm_pkg::fpm_stage_t st;
  fpm_pkg::fpm_stage_t st_next;
  logic [31:0]         res_next;
  logic                adv1;
  logic                adv2;

  logic [31:0] a;
  logic [31:0] b;
  logic [7:0]  ea;
  logic [7:0]  eb;
  logic        an, bn, ai, bi, az, bz;

  assign adv2     = !m_tvalid || m_tready;
  assign adv1     = !v1 || adv2;
  assign s_tready = adv1;

  always_comb begin
    a  = s_tdata[31:0];
    b  = s_tdata[63:32];
    ea = a[30:23];
    eb = b[30:23];
    an = (ea == fpm_pkg::ExpMax) && (a[22:0] != 23'd0);
    bn = (eb == fpm_pkg::ExpMax) && (b[22:0] != 23'd0);
    ai = (ea == fpm_pkg::ExpMax) && (a[22:0] == 23'd0);
    bi = (eb == fpm_pkg::ExpMax) && (b[22:0] == 23'd0);
    az = (ea == 8'd0);
    bz = (eb == 8'd0);
    st_next.sign      = a[31] ^ b[31];
    st_next.is_nan    = an || bn || ((ai || bi) && (az || bz));
    st_next.is_inf    = ai || bi;
    st_next.is_zero   = az || bz;
    st_next.exp_sum   = {1'b0, ea} + {1'b0, eb};
    st_next.mant_prod = {24'd0, 1'b1, a[22:0]} * {24'd0, 1'b1, b[22:0]};
  end

  fpm_round u_round (
    .st      (st),
    .product (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (adv1) v1 <= s_tvalid;
      if (adv2) m_tvalid <= v1;
    end
    if (adv1 && s_tvalid) st <= st_next;
    if (adv2 && v1) m_tdata <= res_next;
  end

`ifndef ASSERT_OFF
  // A result waiting downstream must not be overwritten by the stage behind.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");
  // A NaN result is always the canonical quiet NaN.
  a_qnan: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[30:23] == 8'hFF && m_tdata[22:0] != 23'd0
      |-> m_tdata == fpm_pkg::QnanCanon)
    else $error("non-canonical NaN");
  // Flush to zero: no subnormal result is ever delivered.
  a_ftz: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[30:23] == 8'd0 |-> m_tdata[22:0] == 23'd0)
    else $error("subnormal result");
`endif

endmodule

@@ bench/tb_fp32_multiplier_daz_ftz.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fp32_multiplier_daz_ftz: self-checking bench for the binary32 multiplier
// Directed special operands, then random operand pairs weighted towards
// interesting exponents, checked against a bit-exact integer product model.
// ----------------------------------------------------------------------------
module tb_fp32_multiplier_daz_ftz;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;

  logic [63:0] pending_ops[$];
  logic [31:0] expected_products[$];
  int          mismatches;
  int          cycles;
  bit          stimulus_done;
  bit          quiet_run;

  fp32_multiplier_daz_ftz u_top (.*);

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [31:0] fp32_mul(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] sgn;
    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic [63:0] p, q, rem, half;
    int          e, k, s;
    sgn = (a ^ b) & 32'h8000_0000;
    ea = a[30:23]; eb = b[30:23];
    fa = a[22:0];  fb = b[22:0];
    if ((ea == 8'hFF && fa != 0) || (eb == 8'hFF && fb != 0)) return fpm_pkg::QnanCanon;
    if (ea == 8'hFF || eb == 8'hFF) begin
      if (ea == 0 || eb == 0) return fpm_pkg::QnanCanon;
      return sgn | 32'h7F80_0000;
    end
    if (ea == 0 || eb == 0) return sgn;
    p = 64'({1'b1, fa}) * 64'({1'b1, fb});
    k = p[47] ? 47 : 46;
    e = k + int'(ea) + int'(eb) - 173;
    s = k - 23;
    if (e <= 0) s += 1 - e;
    if (s > 49) s = 49;
    q = p >> s;
    rem = p & ((64'd1 << s) - 1);
    half = 64'd1 << (s - 1);
    if (rem > half || (rem == half && q[0])) q++;
    if (e <= 0) return (q == 64'h80_0000) ? (sgn | 32'h0080_0000) : sgn;
    if (q == 64'h100_0000) begin
      q >>= 1;
      e++;
    end
    if (e >= 255) return sgn | 32'h7F80_0000;
    return sgn | (32'(e) << 23) | (32'(q) & 32'h7F_FFFF);
  endfunction

  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v[30:23] = 8'hFF;
      1: v[30:23] = 8'h00;
      2, 3: v[30:23] = 8'($urandom_range(0, 30));
      4: v[30:23] = 8'($urandom_range(220, 254));
      5: v[22:0] = $urandom_range(0, 1) ? 23'h7F_FFFF : 23'h0;
      default: v[30:23] = 8'($urandom_range(100, 154));
    endcase
    return v;
  endfunction

  // Driver: the queue head is presented until the block takes it.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= quiet_run || ($urandom_range(0, 99) >= 30);
      if (!s_tvalid || s_tready) begin
        if (s_tvalid) begin
          expected_products.push_back(fp32_mul(s_tdata[31:0], s_tdata[63:32]));
          void'(pending_ops.pop_front());
        end
        if (pending_ops.size() != 0 &&
            (quiet_run || $urandom_range(0, 99) >= 30)) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pending_ops[0];
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted product with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_products.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected product %h", m_tdata);
      end else begin
        if (m_tdata !== expected_products[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("product mismatch: expected %h, got %h", expected_products[0], m_tdata);
        end
        void'(expected_products.pop_front());
      end
    end
  end

  initial begin
    logic [31:0] corner[12];
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    mismatches = 0;
    cycles = 0;
    stimulus_done = 1'b0;
    quiet_run = 1'b0;
    corner = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
               32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFF80_0001,
               32'h3F80_0000, 32'h7F7F_FFFF, 32'h0080_0000, 32'h3F00_0000};
    // NaN, infinity against zero and subnormal, overflow and underflow.
    for (int i = 0; i < 12; i += 2) pending_ops.push_back({corner[i+1], corner[i]});
    for (int i = 0; i < 6; i++) pending_ops.push_back({corner[i], corner[4 + (i % 4)]});
    pending_ops.push_back({32'h7F7F_FFFF, 32'h7F7F_FFFF});
    pending_ops.push_back({32'h3F00_0000, 32'h0080_0000});
    pending_ops.push_back({32'h3F7F_FFFF, 32'h0080_0000});
    pending_ops.push_back({32'hFFFF_FFFF, 32'h3F80_0000});
    pending_ops.push_back({32'hBFFF_FFFF, 32'h3FFF_FFFF});
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < 1800; i++) begin
      pending_ops.push_back({pick_operand(), pick_operand()});
      if (i == 600) begin
        wait (pending_ops.size() < 100);
        quiet_run = 1'b1;
      end
      if (i == 900) begin
        // Let the stretch without idling drain before random idling resumes.
        wait (pending_ops.size() < 100);
        quiet_run = 1'b0;
      end
    end
    stimulus_done = 1'b1;
  end

  initial begin
    wait (stimulus_done && pending_ops.size() == 0 && !s_tvalid &&
          expected_products.size() == 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_products.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    wait (cycles >= 200000);
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ filelist.f @@
src/fpm_pkg.sv
src/fpm_round.sv
src/fp32_multiplier_daz_ftz.sv
bench/tb_fp32_multiplier_daz_ftz.sv
